### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

### rtl/frm_pkg.sv
`timescale 1ns / 1ps
package frm_pkg;

  localparam int SAMPLES_DEFAULT = 10;

  localparam int TS_W       = 32;
  localparam int INTERVAL_W = 16;
  localparam int FPS_W      = 22;
  localparam int DELAY_W    = 10;
  localparam int MAX_FPS_W  = 10;

  localparam logic [MAX_FPS_W-1:0] MAX_FPS_RESET = MAX_FPS_W'(60);

  // 1000 fps scaled by 256 for the q8 result
  localparam int FPS_SCALE = 256000;
  localparam logic [FPS_W-1:0] FPS_DEFAULT = FPS_W'(15360);
  localparam int MS_PER_S = 1000;

  // frame event kind on the input tuser bit
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_END   = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/frame_rate_meter_limiter_top.sv
`timescale 1ns / 1ps
// channel   | direction | handshake                      | word
// s_axis    | in        | s_axis_tvalid / s_axis_tready  | tdata timestamp_ms, tuser action
// m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata fps_q8, interval, delay
// cfg       | in        | cfg_valid / cfg_ready          | max_fps
//
// a begin word only stamps the start time; an end word keeps s_axis closed while the one
// restoring divider runs 1000/max_fps then, unless the sum is empty, 256000*count/sum,
// one quotient bit per cycle
// rst is synchronous and active high; max_fps returns to 60, the window empties
// s_axis_tready is low while an end word is in work; the result sits in an output
// register, so the next word is taken while it waits, and a second end word
// holds in its last state until that register is free
`include "assert_macros.svh"
module frame_rate_meter_limiter_top #(
  parameter int SAMPLES = frm_pkg::SAMPLES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  // s_axis: tdata = timestamp_ms[31:0]; tuser = action[0]
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [frm_pkg::TS_W-1:0]  s_axis_tdata,
  input  logic [0:0]                s_axis_tuser,
  // m_axis: tdata = fps_q8[21:0], frame_interval_ms[37:22], delay_ms[47:38]
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [47:0]               m_axis_tdata,
  // cfg: max_fps write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [frm_pkg::MAX_FPS_W-1:0] cfg_data
);
  import frm_pkg::*;

  // window sizes follow the sample count
  localparam int CNT_W  = $clog2(SAMPLES + 1);
  localparam int SLOT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int SUM_W  = INTERVAL_W + CNT_W;
  localparam int DVD_W  = $clog2(FPS_SCALE * SAMPLES + 1);
  localparam logic [DVD_W-1:0] SCALE = DVD_W'(FPS_SCALE);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_READ       = 8'b0000_0010,
    S_UPDATE     = 8'b0000_0100,
    S_FLOOR      = 8'b0000_1000,
    S_FLOOR_WAIT = 8'b0001_0000,
    S_RATE       = 8'b0010_0000,
    S_RATE_WAIT  = 8'b0100_0000,
    S_DONE       = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration and frame timing state
  logic [MAX_FPS_W-1:0]  max_fps;
  logic [TS_W-1:0]       start_time;
  logic [TS_W-1:0]       previous_end_time;
  logic                  primed;
  logic [TS_W-1:0]       now;

  // averaging window
  logic [SLOT_W-1:0]     write_slot;
  logic [CNT_W-1:0]      fill_count;
  logic [SUM_W-1:0]      window_sum;
  logic [INTERVAL_W-1:0] interval;
  logic [INTERVAL_W-1:0] ring_rd;
  logic                  ring_wr;
  logic                  full;

  // divider and results
  logic [DVD_W-1:0]      rate_dvd;
  logic [DELAY_W-1:0]    floor_ms;
  logic [FPS_W-1:0]      fps_q8;
  logic                  div_start;
  logic [DVD_W-1:0]      div_dvd;
  logic [SUM_W-1:0]      div_dvs;
  logic [DVD_W-1:0]      div_quo;
  div_stat_t             div_stat;
  logic [MAX_FPS_W-1:0]  fps_cap;

  logic [TS_W-1:0]       diff;
  logic [TS_W-1:0]       duration;
  logic [DELAY_W-1:0]    delay;
  logic                  out_free;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign full          = (fill_count == CNT_W'(SAMPLES));
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tuser[0] == ACT_END) begin
          state_next = S_READ;
        end
      end
      S_READ:       state_next = S_UPDATE;
      S_UPDATE:     state_next = S_FLOOR;
      S_FLOOR:      state_next = S_FLOOR_WAIT;
      S_FLOOR_WAIT: begin
        if (div_stat.done) begin
          state_next = S_RATE;
        end
      end
      S_RATE: begin
        state_next = (window_sum == '0) ? S_DONE : S_RATE_WAIT;
      end
      S_RATE_WAIT: begin
        if (div_stat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // one divider serves both quotients: the limiter floor, then the rate
  assign fps_cap   = (max_fps == '0) ? MAX_FPS_W'(1) : max_fps;
  assign div_start = (state == S_FLOOR) || (state == S_RATE && window_sum != '0);
  assign div_dvd   = (state == S_FLOOR) ? DVD_W'(MS_PER_S) : rate_dvd;
  assign div_dvs   = (state == S_FLOOR) ? SUM_W'(fps_cap) : window_sum;

  frm_div #(
    .DVD_W (DVD_W),
    .DVS_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // ring of the last intervals, read at the slot about to be overwritten
  assign ring_wr = (state == S_UPDATE);

  frm_ring #(
    .DEPTH (SAMPLES),
    .IDX_W (SLOT_W),
    .W     (INTERVAL_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr),
    .wr_idx  (write_slot),
    .wr_data (interval),
    .rd_idx  (write_slot),
    .rd_data (ring_rd)
  );

  assign diff = now - previous_end_time;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      max_fps           <= MAX_FPS_RESET;
      start_time        <= '0;
      previous_end_time <= '0;
      primed            <= 1'b0;
      write_slot        <= '0;
      fill_count        <= '0;
      window_sum        <= '0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_fps <= cfg_data;
      end
      // frame begin only stamps the start time
      if (state == S_IDLE && s_axis_tvalid && s_axis_tuser[0] == ACT_BEGIN) begin
        start_time <= s_axis_tdata;
      end
      if (state == S_READ) begin
        primed            <= 1'b1;
        previous_end_time <= now;
      end
      if (state == S_UPDATE) begin
        // oldest entry drops out once the window is full
        window_sum <= (full ? window_sum - SUM_W'(ring_rd) : window_sum)
                      + SUM_W'(interval);
        if (!full) begin
          fill_count <= fill_count + 1'b1;
        end
        write_slot <= (write_slot == SLOT_W'(SAMPLES - 1)) ? '0 : write_slot + 1'b1;
      end
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      now <= s_axis_tdata;
    end
    if (state == S_READ) begin
      // first end after reset records zero; longer gaps saturate
      if (!primed) begin
        interval <= '0;
      end else if (|diff[TS_W-1:INTERVAL_W]) begin
        interval <= '1;
      end else begin
        interval <= diff[INTERVAL_W-1:0];
      end
    end
    if (state == S_UPDATE) begin
      rate_dvd <= SCALE * DVD_W'(full ? fill_count : fill_count + 1'b1);
    end
    if (state == S_FLOOR_WAIT && div_stat.done) begin
      floor_ms <= DELAY_W'(div_quo);
    end
    if (state == S_RATE && window_sum == '0) begin
      fps_q8 <= FPS_DEFAULT;
    end
    if (state == S_RATE_WAIT && div_stat.done) begin
      fps_q8 <= FPS_W'(div_quo);
    end
  end

  // limiter delay: floor minus frame duration, clipped at zero
  assign duration = now - start_time;
  assign delay    = (TS_W'(floor_ms) > duration) ? DELAY_W'(TS_W'(floor_ms) - duration) : '0;

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= {delay, interval, fps_q8};
    end
  end

  `ASSERT_IMPLY(a_fill_bound, clk, rst, 1'b1, fill_count <= CNT_W'(SAMPLES))
  `ASSERT_IMPLY(a_empty_sum, clk, rst, fill_count == '0, window_sum == '0)
  `ASSERT_IMPLY(a_idle_div, clk, rst, s_axis_tready, !div_stat.busy)
  `ASSERT_NEXT(a_hold_result, clk, rst, state == S_DONE && !out_free, state == S_DONE && m_axis_tvalid)

endmodule

### rtl/frm_div.sv
`timescale 1ns / 1ps
module frm_div #(
  parameter int DVD_W = 22,
  parameter int DVS_W = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DVD_W-1:0]        dividend,
  input  logic [DVS_W-1:0]        divisor,
  output logic [DVD_W-1:0]        quotient,
  output frm_pkg::div_stat_t      stat
);
  import frm_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DVS_W:0]   trial;
  logic             fits;

  // one restoring step per cycle
  assign trial = {rem, quo[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### rtl/frm_ring.sv
`timescale 1ns / 1ps
module frm_ring #(
  parameter int DEPTH = 10,
  parameter int IDX_W = 4,
  parameter int W     = 16
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [W-1:0]     wr_data,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [W-1:0]     rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
  end

endmodule

### tb/frame_rate_meter_limiter_checker.sv
`timescale 1ns / 1ps
module frame_rate_meter_limiter_checker #(
  parameter int SAMPLES = frm_pkg::SAMPLES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [frm_pkg::TS_W-1:0]      s_axis_tdata,
  input  logic [0:0]                    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [47:0]                   m_axis_tdata,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [frm_pkg::MAX_FPS_W-1:0] cfg_data,
  output int                            mismatches,
  output int                            results_owed
);
  import frm_pkg::*;

  // packed so that fps_q8 sits in the low bits, as on m_axis_tdata
  typedef struct packed {
    logic [DELAY_W-1:0]    delay_ms;
    logic [INTERVAL_W-1:0] interval_ms;
    logic [FPS_W-1:0]      fps_q8;
  } frame_stats_t;

  logic [MAX_FPS_W-1:0]  fps_ceiling;
  logic [TS_W-1:0]       frame_start;
  logic [TS_W-1:0]       last_end;
  logic                  seen_end;
  logic [INTERVAL_W-1:0] window [SAMPLES];
  int unsigned           slot;
  int unsigned           filled;
  logic [19:0]           window_sum;
  frame_stats_t          stats_q [$];

  function automatic frame_stats_t close_frame(input logic [TS_W-1:0] now);
    frame_stats_t    s;
    logic [TS_W-1:0] since_end;
    logic [TS_W-1:0] duration;
    logic [63:0]     rate;
    int unsigned     cap;
    int unsigned     budget;
    if (!seen_end) begin
      s.interval_ms = '0;
    end else begin
      since_end = now - last_end;
      s.interval_ms = (since_end > 32'h0000_FFFF) ? '1 : since_end[INTERVAL_W-1:0];
    end
    seen_end = 1'b1;
    last_end = now;
    // once the window is full the oldest interval drops out of the sum
    if (filled >= SAMPLES) begin
      window_sum = window_sum - window[slot];
    end else begin
      filled++;
    end
    window[slot] = s.interval_ms;
    window_sum = window_sum + s.interval_ms;
    slot = (slot + 1 >= SAMPLES) ? 0 : slot + 1;
    if (window_sum == 0) begin
      s.fps_q8 = FPS_DEFAULT;
    end else begin
      rate = 64'(FPS_SCALE) * filled / window_sum;
      s.fps_q8 = (rate > 64'h3F_FFFF) ? '1 : rate[FPS_W-1:0];
    end
    // a ceiling of zero acts as one frame per second
    cap = (fps_ceiling == 0) ? 1 : fps_ceiling;
    budget = MS_PER_S / cap;
    duration = now - frame_start;
    s.delay_ms = (budget > duration) ? DELAY_W'(budget - duration) : '0;
    return s;
  endfunction

  always @(posedge clk) begin
    frame_stats_t got;
    frame_stats_t want;
    if (rst) begin
      fps_ceiling = MAX_FPS_RESET;
      frame_start = '0;
      last_end    = '0;
      seen_end    = 1'b0;
      slot        = 0;
      filled      = 0;
      window_sum  = '0;
      mismatches  = 0;
      stats_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        fps_ceiling = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == ACT_BEGIN) begin
          frame_start = s_axis_tdata;
        end else begin
          stats_q.push_back(close_frame(s_axis_tdata));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = frame_stats_t'(m_axis_tdata);
        if (stats_q.size() == 0) begin
          $error("unexpected result word %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = stats_q.pop_front();
          if (got.fps_q8 !== want.fps_q8) begin
            $error("fps_q8 expected %0d actual %0d", want.fps_q8, got.fps_q8);
            mismatches++;
          end
          if (got.interval_ms !== want.interval_ms) begin
            $error("frame_interval_ms expected %0d actual %0d",
                   want.interval_ms, got.interval_ms);
            mismatches++;
          end
          if (got.delay_ms !== want.delay_ms) begin
            $error("delay_ms expected %0d actual %0d", want.delay_ms, got.delay_ms);
            mismatches++;
          end
        end
      end
    end
    results_owed <= stats_q.size();
  end

endmodule

### tb/frame_rate_meter_limiter_top_tb.sv
`timescale 1ns / 1ps
module frame_rate_meter_limiter_top_tb;
  import frm_pkg::*;

  // pause that lets an end word clear the divider
  localparam int SETTLE_CYCLES   = 80;
  // room for ~500 worst-case words, plus phase pauses, several times over
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int WORDS_PER_PHASE = 64;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TS_W-1:0]       s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [47:0]           m_axis_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [MAX_FPS_W-1:0]  cfg_data;

  int                    mismatches;
  int                    results_owed;
  int unsigned           cycles = 0;
  bit                    tx_calm;
  bit                    rx_calm;
  int                    rx_hold;
  logic [TS_W-1:0]       clock_ms;

  frame_rate_meter_limiter_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  frame_rate_meter_limiter_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .results_owed  (results_owed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // mostly short idles, now and then a long one
  function automatic int idle_span();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(20, 64);
  endfunction

  function automatic int sender_gap();
    if (tx_calm || $urandom_range(0, 99) < 50) begin
      return 0;
    end
    return idle_span();
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= 0;
    end else if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= rx_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 99) < 30) begin
        rx_hold <= idle_span();
      end
    end
  end

  // valid stays high into the next word when no gap is drawn
  task automatic send_word(input logic act, input logic [TS_W-1:0] ts);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= ts;
    do @(posedge clk); while (!s_axis_tready);
    gap = sender_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [TS_W-1:0] dur);
    send_word(ACT_BEGIN, clock_ms);
    clock_ms = clock_ms + dur;
    send_word(ACT_END, clock_ms);
    clock_ms = clock_ms + $urandom_range(0, 20);
  endtask

  // the owed count is registered, so it trails the word handshake
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic set_ceiling(input logic [MAX_FPS_W-1:0] fps);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= fps;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TS_W-1:0] frame_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(0, 40);
    end else if (r < 95) begin
      return $urandom_range(0, 1100);
    end
    return $urandom_range(1100, 70000);
  endfunction

  task automatic directed_frames();
    // end with no begin yet, first interval is zero
    send_word(ACT_END, 32'd5);
    send_word(ACT_BEGIN, 32'd100);
    send_word(ACT_END, 32'd110);
    // tick counter wrapping inside a frame
    send_word(ACT_BEGIN, 32'hFFFF_FFF0);
    send_word(ACT_END, 32'h0000_0005);
    // time running backwards, for the interval and then for the duration
    send_word(ACT_END, 32'h0000_0002);
    send_word(ACT_BEGIN, 32'd500);
    send_word(ACT_END, 32'd400);
    // zero-length frame at the top of the range
    send_word(ACT_BEGIN, 32'hFFFF_FFFF);
    send_word(ACT_END, 32'hFFFF_FFFF);
    send_word(ACT_BEGIN, 32'h5555_5555);
    send_word(ACT_END, 32'hAAAA_AAAA);
    // interval right at and just past saturation
    send_word(ACT_END, 32'hAAAA_AAAA + 32'd65535);
    send_word(ACT_END, 32'hAAAA_AAAA + 32'd65535 + 32'd65536);
    // a window of zero intervals falls back to the default rate
    repeat (11) send_word(ACT_END, 32'h0000_1000);
    // nine zeros and a one give the highest rate
    send_word(ACT_END, 32'h0000_1001);
    clock_ms = 32'h0000_1010;
  endtask

  task automatic random_frames(input int words);
    int sent;
    int kind;
    int steps;
    logic [TS_W-1:0] step;
    sent = 0;
    while (sent < words) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_frame(frame_length());
        sent += 2;
      end else if (kind < 78) begin
        // steady run of ends that fills and turns over the window
        steps = $urandom_range(10, 14);
        step  = $urandom_range(0, 3);
        repeat (steps) begin
          clock_ms = clock_ms + step;
          send_word(ACT_END, clock_ms);
        end
        sent += steps;
      end else if (kind < 84) begin
        clock_ms = $urandom();
        send_frame(frame_length());
        sent += 2;
      end else if (kind < 89) begin
        clock_ms = clock_ms + $urandom_range(0, 50);
        send_word(ACT_END, clock_ms);
        sent += 1;
      end else if (kind < 93) begin
        send_word(ACT_BEGIN, clock_ms);
        clock_ms = clock_ms + $urandom_range(0, 20);
        sent += 1;
      end else if (kind < 97) begin
        clock_ms = clock_ms + $urandom_range(65530, 65540);
        send_word(ACT_END, clock_ms);
        sent += 1;
      end else begin
        clock_ms = clock_ms - $urandom_range(1, 100);
        send_word(ACT_END, clock_ms);
        sent += 1;
      end
      // now and then let the pipe run dry before going on
      if ($urandom_range(0, 29) == 0) begin
        wait_results();
      end
    end
  endtask

  initial begin
    logic [MAX_FPS_W-1:0] ceiling_plan [6];
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_BEGIN;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    ceiling_plan  = '{MAX_FPS_W'(1), MAX_FPS_W'(1000), MAX_FPS_W'(0), MAX_FPS_W'(1023),
                      MAX_FPS_W'($urandom_range(2, 999)), MAX_FPS_W'(30)};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first phase runs on the reset ceiling of 60
    directed_frames();
    random_frames(WORDS_PER_PHASE);
    foreach (ceiling_plan[p]) begin
      set_ceiling(ceiling_plan[p]);
      tx_calm = (p == 2);
      rx_calm = (p == 2 || p == 4);
      random_frames(WORDS_PER_PHASE);
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
